### rtl/core/ltc_pkg.sv
// Shared types and constants for the lexical token classifier.
`default_nettype none
package ltc_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0] token_class;
    logic       line_last;
  } out_item_t;

  localparam logic [2:0] CLS_KEYWORD  = 3'd0;
  localparam logic [2:0] CLS_OPERATOR = 3'd1;
  localparam logic [2:0] CLS_INTEGER  = 3'd2;
  localparam logic [2:0] CLS_FLOAT    = 3'd3;
  localparam logic [2:0] CLS_DOUBLE   = 3'd4;
  localparam logic [2:0] CLS_IDENT    = 3'd5;
  localparam logic [2:0] CLS_INVALID  = 3'd6;

  // Results that one stepped character hands to the output queue (none, one or two).
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } push_req_t;

endpackage
`default_nettype wire

### rtl/core/ltc_token_state.sv
// Running token state, per-character update and token classification.
`default_nettype none
module ltc_token_state (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  ltc_pkg::in_item_t item,
  output ltc_pkg::push_req_t push
);
  import ltc_pkg::*;

  localparam int KW_COUNT = 14;
  localparam logic [7:0] SPACE_CODE = 8'h20;
  localparam logic [7:0] DOT_CODE   = 8'h2E;

  // Keywords are stored left-justified, one byte per character.
  localparam logic [71:0] KW_TEXT [KW_COUNT] = '{
    {"int", 48'h0}, {"float", 32'h0}, {"double", 24'h0}, {"include", 16'h0},
    {"if", 56'h0}, {"else", 40'h0}, {"namespace"}, {"void", 40'h0},
    {"main", 40'h0}, {"return", 24'h0}, {"define", 24'h0}, {"do", 56'h0},
    {"while", 32'h0}, {"for", 48'h0}
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd5, 4'd6, 4'd7, 4'd2, 4'd4, 4'd9, 4'd4, 4'd4, 4'd6, 4'd6, 4'd2, 4'd5, 4'd3
  };

  typedef enum logic [8:0] {
    PH_START   = 9'b000000001,
    PH_SIGN    = 9'b000000010,
    PH_INT     = 9'b000000100,
    PH_DOT     = 9'b000001000,
    PH_FRAC    = 9'b000010000,
    PH_EXP     = 9'b000100000,
    PH_EXPSIGN = 9'b001000000,
    PH_EXPDIG  = 9'b010000000,
    PH_DEAD    = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [KW_COUNT-1:0] kw_hits;
    logic [3:0]          pos;
    phase_t              phase;
    logic [1:0]          after_dot;
    logic                dot_seen;
    logic                digit_seen;
    logic                first_alpha;
    logic                first_operator;
  } tok_state_t;

  localparam tok_state_t TOK_CLEAR = '{
    kw_hits: '1, pos: 4'd0, phase: PH_START, after_dot: 2'd0,
    dot_seen: 1'b0, digit_seen: 1'b0, first_alpha: 1'b0, first_operator: 1'b0
  };

  function automatic logic [7:0] kw_byte(input logic [71:0] word, input logic [3:0] pos);
    logic [71:0] sh;
    sh = word << {pos, 3'b000};
    return sh[71:64];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == 8'h2B) || (c == 8'h2D);
  endfunction

  function automatic logic is_exp(input logic [7:0] c);
    return (c == 8'h45) || (c == 8'h65);
  endfunction

  function automatic logic is_oper(input logic [7:0] c);
    return (c == 8'h2B) || (c == 8'h2D) || (c == 8'h25) || (c == 8'h2A) ||
           (c == 8'h2F) || (c == 8'h5E);
  endfunction

  function automatic phase_t next_phase(input phase_t ph, input logic [7:0] c);
    phase_t nx;
    logic   d;
    logic   dot;
    d   = is_digit(c);
    dot = (c == DOT_CODE);
    nx  = PH_DEAD;
    unique case (ph)
      PH_START: begin
        if (is_sign(c)) nx = PH_SIGN;
        else if (d) nx = PH_INT;
        else if (dot) nx = PH_DOT;
      end
      PH_SIGN: begin
        if (d) nx = PH_INT;
        else if (dot) nx = PH_DOT;
      end
      PH_INT: begin
        if (d) nx = PH_INT;
        else if (dot) nx = PH_DOT;
        else if (is_exp(c)) nx = PH_EXP;
      end
      PH_DOT: begin
        if (d) nx = PH_FRAC;
      end
      PH_FRAC: begin
        if (d) nx = PH_FRAC;
        else if (is_exp(c)) nx = PH_EXP;
      end
      PH_EXP: begin
        if (is_sign(c)) nx = PH_EXPSIGN;
        else if (d) nx = PH_EXPDIG;
      end
      PH_EXPSIGN: begin
        if (d) nx = PH_EXPDIG;
      end
      PH_EXPDIG: begin
        if (d) nx = PH_EXPDIG;
      end
      default: nx = PH_DEAD;
    endcase
    return nx;
  endfunction

  function automatic tok_state_t add_char(input tok_state_t s, input logic [7:0] c);
    tok_state_t n;
    n = s;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (!((s.pos < KW_LEN[k]) && (kw_byte(KW_TEXT[k], s.pos) == c))) begin
        n.kw_hits[k] = 1'b0;
      end
    end
    if (s.pos == 4'd0) begin
      n.first_alpha    = is_alpha(c);
      n.first_operator = is_oper(c);
    end
    if (is_digit(c)) n.digit_seen = 1'b1;
    if (s.dot_seen) begin
      if (s.after_dot != 2'd3) n.after_dot = s.after_dot + 2'd1;
    end else if (c == DOT_CODE) begin
      n.dot_seen = 1'b1;
    end
    n.phase = next_phase(s.phase, c);
    if (s.pos != 4'd15) n.pos = s.pos + 4'd1;
    return n;
  endfunction

  function automatic logic [2:0] classify(input tok_state_t s);
    logic       kw_match;
    logic [2:0] cls;
    kw_match = 1'b0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (s.kw_hits[k] && (s.pos == KW_LEN[k])) kw_match = 1'b1;
    end
    if (s.pos == 4'd0) cls = CLS_INVALID;
    else if (kw_match) cls = CLS_KEYWORD;
    else if ((s.pos == 4'd1) && s.first_operator) cls = CLS_OPERATOR;
    else if ((s.phase == PH_INT) || (s.phase == PH_FRAC) || (s.phase == PH_EXPDIG)) begin
      if (!s.dot_seen) cls = CLS_INTEGER;
      else if (s.after_dot == 2'd3) cls = CLS_DOUBLE;
      else cls = CLS_FLOAT;
    end else if (s.first_alpha) cls = s.digit_seen ? CLS_INVALID : CLS_IDENT;
    else cls = CLS_INVALID;
    return cls;
  endfunction

  tok_state_t state_r, state_nxt;
  tok_state_t added;
  logic       is_space;

  always_comb begin
    is_space    = (item.char_code == SPACE_CODE);
    added       = add_char(state_r, item.char_code);
    push        = '0;
    push.second = '{token_class: CLS_INVALID, line_last: 1'b1};
    state_nxt   = state_r;
    if (step) begin
      if (is_space) begin
        // A space closes the current token; at line end the empty token after it follows.
        push.first = '{token_class: classify(state_r), line_last: 1'b0};
        push.count = item.line_end ? 2'd2 : 2'd1;
        state_nxt  = TOK_CLEAR;
      end else if (item.line_end) begin
        push.first = '{token_class: classify(added), line_last: 1'b1};
        push.count = 2'd1;
        state_nxt  = TOK_CLEAR;
      end else begin
        state_nxt = added;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TOK_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/core/ltc_out_fifo.sv
// Four-entry result queue taking up to two results per cycle.
`default_nettype none
module ltc_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  ltc_pkg::push_req_t  push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output ltc_pkg::out_item_t  out_data
);
  import ltc_pkg::*;

  out_item_t  mem [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;

  // Room for two more entries is judged before this cycle's pop.
  assign room      = (count_r <= 3'd2);
  assign out_valid = (count_r != 3'd0);
  assign out_data  = mem[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push.count;
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    count_nxt  = count_r + {1'b0, push.count} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr_r] <= push.first;
    if (push.count == 2'd2) mem[wr_ptr_r + 2'd1] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/core/lexical_token_classifier_core.sv
// Top level of the lexical token classifier.
//
//   Channel | Direction | Payload fields
//   in_     | input     | char_code[7:0], line_end
//   out_    | output    | token_class[2:0], line_last
//
// One character is taken per cycle while the result queue has room. A character
// is captured in the input register, is folded into the token state once the
// queue has room, and any result it causes is written into the queue at that
// edge and then offered on out_. A space at line end yields two results from one
// character. Synchronous reset clears the token state, the queue and the input
// register's valid flag. Input is held off only while the input register is full
// and the four-entry result queue has fewer than two free slots.
`default_nettype none
module lexical_token_classifier_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ltc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ltc_pkg::out_item_t out_data
);
  import ltc_pkg::*;

  logic      stage_valid_r, stage_valid_nxt;
  in_item_t  stage_item_r;
  logic      room;
  logic      step;
  logic      in_fire;
  push_req_t push;

  assign step     = stage_valid_r && room;
  assign in_ready = !stage_valid_r || room;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (in_fire) stage_valid_nxt = 1'b1;
    else if (step) stage_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_fire) stage_item_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  ltc_token_state u_token (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (stage_item_r),
    .push  (push)
  );

  ltc_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
